// ===== src/cma_pkg.sv =====
// shared types and constants of the centred moving average block
package cma_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int FRAC_BITS      = 8;
  localparam int AVG_W          = 24;
  localparam int RADIUS_W       = 5;
  localparam int MAX_RADIUS_DEF = 31;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_stream;
  } item_beat_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic                    final_result;
  } avg_beat_t;

  typedef struct packed {
    logic accept;
    logic ring_upd;
    logic sum_upd;
    logic div_start_win;
    logic div_start_flush;
    logic div_step;
    logic load_out;
    logic flush_init;
    logic flush_read;
    logic flush_remove;
    logic flush_dec;
    logic end_stream;
  } cma_cmd_t;

  typedef struct packed {
    logic eos;
    logic emit_now;
    logic flush_none;
    logic flushing;
    logic d_zero;
    logic curm_gt_m;
    logic div_done;
    logic out_free;
  } cma_stat_t;

endpackage

// ===== src/cma_ctrl.sv =====
// sequencing state machine of the centred moving average block
module cma_ctrl
  import cma_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  cma_stat_t stat,
  output cma_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RING  = 9'b000000010,
    S_SUM   = 9'b000000100,
    S_ROUTE = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_LOAD  = 9'b000100000,
    S_FINIT = 9'b001000000,
    S_FCHK  = 9'b010000000,
    S_FREM  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = S_RING;
        end
      end
      S_RING: begin
        cmd.ring_upd = 1'b1;
        state_next   = S_SUM;
      end
      S_SUM: begin
        cmd.sum_upd = 1'b1;
        state_next  = S_ROUTE;
      end
      S_ROUTE: begin
        if (stat.emit_now) begin
          cmd.div_start_win = 1'b1;
          state_next        = S_DIV;
        end else if (stat.eos) begin
          state_next = S_FINIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_LOAD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (stat.flushing) begin
            if (stat.d_zero) begin
              cmd.end_stream = 1'b1;
              state_next     = S_IDLE;
            end else begin
              cmd.flush_dec = 1'b1;
              state_next    = S_FCHK;
            end
          end else if (stat.eos) begin
            if (stat.flush_none) begin
              cmd.end_stream = 1'b1;
              state_next     = S_IDLE;
            end else begin
              state_next = S_FINIT;
            end
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_FINIT: begin
        cmd.flush_init = 1'b1;
        state_next     = S_FCHK;
      end
      S_FCHK: begin
        if (stat.curm_gt_m) begin
          cmd.flush_read = 1'b1;
          state_next     = S_FREM;
        end else begin
          cmd.div_start_flush = 1'b1;
          state_next          = S_DIV;
        end
      end
      S_FREM: begin
        cmd.flush_remove = 1'b1;
        state_next       = S_FCHK;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/cma_datapath.sv =====
// sample ring, window sums, serial divider and output register
module cma_datapath
  import cma_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  item_beat_t          item,
  input  logic                cfg_valid,
  input  logic [RADIUS_W-1:0] cfg_data,
  input  cma_cmd_t            cmd,
  output cma_stat_t           stat,
  output logic                avg_valid,
  input  logic                avg_stall,
  output avg_beat_t           avg
);

  localparam int DEPTH  = 2 * MAX_RADIUS + 2;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int SEEN_W = $clog2(DEPTH + 1);
  localparam int K_W    = $clog2(MAX_RADIUS + 1);
  localparam int CNT_W  = $clog2(2 * MAX_RADIUS + 2);
  localparam int SUM_W  = SAMPLE_W + CNT_W + 1;
  localparam int MAG_W  = SUM_W + FRAC_BITS;
  localparam int DC_W   = $clog2(MAG_W + 1);

  // ring memory
  logic signed [SAMPLE_W-1:0] ring [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic [IDX_W-1:0]           rd_addr;
  logic [CNT_W-1:0]           rd_off;

  logic [RADIUS_W-1:0]        radius;
  logic [K_W-1:0]             k;
  logic [IDX_W-1:0]           newest;
  logic [SEEN_W-1:0]          seen;
  logic [SEEN_W-1:0]          j;
  logic signed [SAMPLE_W-1:0] s_reg;
  logic                       eos;
  logic signed [SUM_W-1:0]    window_sum;

  logic                       flushing;
  logic signed [SUM_W-1:0]    cur;
  logic [CNT_W-1:0]           curm;
  logic [K_W-1:0]             d;

  logic [CNT_W-1:0]           div_n;
  logic [CNT_W-1:0]           rem;
  logic [MAG_W-1:0]           quo;
  logic                       neg;
  logic                       last;
  logic [DC_W-1:0]            div_cnt;

  logic [CNT_W-1:0]           two_k;
  logic [CNT_W-1:0]           two_k1;
  logic [CNT_W-1:0]           span;
  logic [CNT_W-1:0]           dk;
  logic [CNT_W-1:0]           m;
  logic [IDX_W:0]             base_e;
  logic [IDX_W:0]             off_e;
  logic signed [SUM_W-1:0]    div_sum;
  logic [SUM_W-1:0]           abs_sum;
  logic [CNT_W:0]             rem_sh;
  logic [CNT_W:0]             trial;
  logic signed [MAG_W:0]      q_signed;
  logic                       sub_old;

  assign two_k   = {k, 1'b0};
  assign two_k1  = {k, 1'b1};
  assign span    = (j < SEEN_W'(two_k)) ? CNT_W'(j) : two_k;
  assign dk      = CNT_W'(d) + CNT_W'(k);
  assign m       = (SEEN_W'(dk) > j) ? CNT_W'(j) : dk;
  assign sub_old = (j >= SEEN_W'(two_k1));

  // address of the sample rd_off places behind the newest one
  assign rd_off = cmd.flush_read ? curm : two_k1;
  assign base_e = {1'b0, newest};
  assign off_e  = (IDX_W + 1)'(rd_off);
  always_comb begin
    if (base_e >= off_e) begin
      rd_addr = IDX_W'(base_e - off_e);
    end else begin
      rd_addr = IDX_W'(base_e + (IDX_W + 1)'(DEPTH) - off_e);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ring_upd) begin
      ring[newest] <= s_reg;
    end
    if (cmd.ring_upd || cmd.flush_read) begin
      rd_data <= ring[rd_addr];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RST;
    end else if (cfg_valid) begin
      radius <= cfg_data;
    end
  end

  // stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      k          <= '0;
      newest     <= '0;
      seen       <= '0;
      window_sum <= '0;
      flushing   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (seen == '0) begin
          if (int'(radius) > MAX_RADIUS) begin
            k <= K_W'(MAX_RADIUS);
          end else begin
            k <= K_W'(radius);
          end
        end
        newest <= (newest == IDX_W'(DEPTH - 1)) ? '0 : newest + 1'b1;
        if (seen != SEEN_W'(DEPTH)) begin
          seen <= seen + 1'b1;
        end
      end
      if (cmd.sum_upd) begin
        window_sum <= window_sum + SUM_W'(s_reg) - (sub_old ? SUM_W'(rd_data) : SUM_W'(0));
      end
      if (cmd.flush_init) begin
        flushing <= 1'b1;
      end
      if (cmd.end_stream) begin
        seen       <= '0;
        window_sum <= '0;
        flushing   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_reg <= item.sample;
      eos   <= item.end_of_stream;
      j     <= seen;
    end
    if (cmd.flush_init) begin
      cur  <= window_sum;
      curm <= span;
      d    <= (j >= SEEN_W'(k)) ? k - 1'b1 : K_W'(j);
    end
    if (cmd.flush_remove) begin
      cur  <= cur - SUM_W'(rd_data);
      curm <= curm - 1'b1;
    end
    if (cmd.flush_dec) begin
      d <= d - 1'b1;
    end
  end

  // serial restoring divider, one quotient bit a cycle
  assign div_sum = cmd.div_start_win ? window_sum : cur;
  assign abs_sum = div_sum[SUM_W-1] ? SUM_W'(-div_sum) : SUM_W'(div_sum);
  assign rem_sh  = {rem, quo[MAG_W-1]};
  assign trial   = rem_sh - {1'b0, div_n};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start_win || cmd.div_start_flush) begin
      div_cnt <= DC_W'(MAG_W);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start_win || cmd.div_start_flush) begin
      quo   <= MAG_W'(abs_sum) << FRAC_BITS;
      rem   <= '0;
      neg   <= div_sum[SUM_W-1];
      div_n <= cmd.div_start_win ? span + 1'b1 : m + 1'b1;
      last  <= cmd.div_start_win ? (eos && (k == '0)) : (d == '0);
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, div_n}) begin
        rem <= CNT_W'(trial);
        quo <= {quo[MAG_W-2:0], 1'b1};
      end else begin
        rem <= CNT_W'(rem_sh);
        quo <= {quo[MAG_W-2:0], 1'b0};
      end
    end
  end

  // output register
  assign q_signed = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_valid <= 1'b0;
    end else if (cmd.load_out) begin
      avg_valid <= 1'b1;
    end else if (!avg_stall) begin
      avg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      avg.average      <= AVG_W'(q_signed);
      avg.final_result <= last;
    end
  end

  always_comb begin
    stat.eos        = eos;
    stat.emit_now   = (j >= SEEN_W'(k));
    stat.flush_none = (k == '0);
    stat.flushing   = flushing;
    stat.d_zero     = (d == '0);
    stat.curm_gt_m  = (curm > m);
    stat.div_done   = (div_cnt == '0);
    stat.out_free   = !avg_valid || !avg_stall;
  end

`ifndef SYNTHESIS
  a_out_free : assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!avg_valid || !avg_stall))
    else $error("result loaded over a waiting beat");

  a_div_nonzero : assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (div_n != '0))
    else $error("divider running with zero divisor");

  a_seen_cap : assert property (@(posedge clk) disable iff (rst)
    seen <= SEEN_W'(DEPTH))
    else $error("sample count beyond ring depth");

  a_end_clears : assert property (@(posedge clk) disable iff (rst)
    cmd.end_stream |=> (seen == '0) && (window_sum == '0) && !flushing)
    else $error("stream state not cleared at end of stream");
`endif

endmodule

// ===== src/centered_moving_average.sv =====
// top level of the centred moving average block
// Takes one sample beat at a time and returns, for every stream position, the mean of the
// samples within window_radius on either side, the window clipped at both stream ends and
// divided by the samples actually inside it; means carry FRAC_BITS fraction bits, truncated
// toward zero. A mean leaves once the sample window_radius places later has arrived, and the
// end-of-stream beat releases all remaining means, the last one flagged final_result. The
// radius is taken at the first sample of each stream and clipped to MAX_RADIUS. Each sample
// passes through the accept, ring update, sum update and routing steps, and every mean it
// produces adds a run of the bit-serial divider and a load of the output register; the
// end-of-stream flush adds a set-up step, a division for each mean it releases, and a ring
// read and a removal for each sample dropped from the shrinking window. A finished mean waits
// in an output register, so a stalled output only holds the block once the next mean is ready.
module centered_moving_average
  import cma_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  item_beat_t          item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [RADIUS_W-1:0] cfg_data,
  output logic                avg_valid,
  input  logic                avg_stall,
  output avg_beat_t           avg
);

  cma_cmd_t  cmd;
  cma_stat_t stat;

  assign cfg_ready = 1'b1;

  cma_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  cma_datapath #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .avg_valid (avg_valid),
    .avg_stall (avg_stall),
    .avg       (avg)
  );

endmodule
